// ----- src/adg_pkg.sv -----
// Shared types and constants of the acyclic dependency graph engine.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package adg_pkg;

	localparam int OP_W     = 3;
	localparam int NODE_W   = 4;
	localparam int SET_W    = 16;
	localparam int STATUS_W = 2;
	localparam int MAX_NODES = 64;
	localparam int MAX_RESULTS = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD_NODE  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_EDGE  = 3'd1;
	localparam logic [OP_W-1:0] OP_GET_DEPS  = 3'd2;
	localparam logic [OP_W-1:0] OP_GET_DEPTS = 3'd3;
	localparam logic [OP_W-1:0] OP_SORT      = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EDGE_CYCLE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SORT_CYCLE = 2'd3;

	// Index of the last result slot of one transaction.
	localparam logic [3:0] KC_LAST = 4'(MAX_RESULTS - 1);

	// Matrix read address selection.
	localparam logic [1:0] RD_CNT  = 2'd0;
	localparam logic [1:0] RD_A    = 2'd1;
	localparam logic [1:0] RD_PICK = 2'd2;
	localparam logic [1:0] RD_CUR  = 2'd3;

	typedef struct packed {
		logic                load_item;
		logic                set_present;
		logic [1:0]          rd_sel;
		logic                reach_init;
		logic                reach_pick;
		logic                reach_or;
		logic                edge_write;
		logic                cnt_clear;
		logic                cnt_inc;
		logic                set_clear;
		logic                set_col;
		logic                set_row;
		logic                sort_init;
		logic                deg_acc;
		logic                ready_init;
		logic                push;
		logic                pop;
		logic                visit;
		logic                relax;
		logic                emit;
		logic [STATUS_W-1:0] emit_status;
		logic                emit_set;
		logic                emit_node;
		logic                emit_last;
	} adg_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            a_range;
		logic            a_ok;
		logic            b_ok;
		logic            cnt_last;
		logic            frontier_any;
		logic            reach_hit;
		logic            ready_any;
		logic            stack_empty;
		logic            hold_vld;
		logic            kc_room;
		logic            sort_cycle;
		logic            out_free;
	} adg_stat_t;

	// Index of the lowest set bit; zero when none is set.
	function automatic logic [5:0] lowest_bit(input logic [MAX_NODES-1:0] v);
		logic [5:0] idx;
		idx = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// ----- src/adg_if.sv -----
// Valid/ready channel interfaces for request and response transactions.
// Depends on adg_pkg for field widths.
`default_nettype none
interface adg_in_if;
	logic                        valid;
	logic                        ready;
	logic [adg_pkg::OP_W-1:0]    operation;
	logic [adg_pkg::NODE_W-1:0]  node_a;
	logic [adg_pkg::NODE_W-1:0]  node_b;
	modport source (output valid, operation, node_a, node_b, input ready);
	modport sink   (input valid, operation, node_a, node_b, output ready);
endinterface

interface adg_out_if;
	logic                          valid;
	logic                          ready;
	logic [adg_pkg::STATUS_W-1:0]  status;
	logic [adg_pkg::SET_W-1:0]     node_set;
	logic [adg_pkg::NODE_W-1:0]    order_node;
	logic                          order_valid;
	logic                          last;
	modport source (output valid, status, node_set, order_node, order_valid, last,
		input ready);
	modport sink   (input valid, status, node_set, order_node, order_valid, last,
		output ready);
endinterface
`default_nettype wire

// ----- src/acyclic_dependency_graph_engine.sv -----
// Add edge first searches the nodes reachable from the target; dependencies scan every
// matrix row, dependents read one row; sort runs a degree pass, then visits each node.
// One transaction is processed at a time; the single matrix read port sets the pace.
// Reset (arst_n low) empties the graph at once; no clearing pass is needed.
`default_nettype none
module acyclic_dependency_graph_engine #(
	parameter int NODES = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	adg_in_if.sink     req,
	adg_out_if.source  rsp
);

	// The controller walks each operation as a sequence of commands; the
	// datapath holds the graph, the matrix memory, the sort stack and the
	// output register, and reports conditions back as a status struct.
	adg_pkg::adg_cmd_t  cmd;
	adg_pkg::adg_stat_t stat;

	adg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Results leave through a registered stage so that a transaction waits
	// there without holding up the sequencer until the next one is due.
	adg_dpath #(
		.NODES (NODES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (req.operation),
		.node_a          (req.node_a),
		.node_b          (req.node_b),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_status      (rsp.status),
		.out_node_set    (rsp.node_set),
		.out_order_node  (rsp.order_node),
		.out_order_valid (rsp.order_valid),
		.out_last        (rsp.last)
	);

endmodule
`default_nettype wire

// ----- src/adg_dpath.sv -----
// Datapath: presence mask, adjacency matrix memory, reach search, degree lanes,
// sort stack memory and the output register. Depends on adg_pkg.
`default_nettype none
module adg_dpath #(
	parameter int NODES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire adg_pkg::adg_cmd_t             cmd,
	output adg_pkg::adg_stat_t                 stat,
	input  wire logic [adg_pkg::OP_W-1:0]      operation,
	input  wire logic [adg_pkg::NODE_W-1:0]    node_a,
	input  wire logic [adg_pkg::NODE_W-1:0]    node_b,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [adg_pkg::STATUS_W-1:0]       out_status,
	output logic [adg_pkg::SET_W-1:0]          out_node_set,
	output logic [adg_pkg::NODE_W-1:0]         out_order_node,
	output logic                               out_order_valid,
	output logic                               out_last
);

	localparam int IW = $clog2(NODES);
	localparam int SW = $clog2(NODES + 1);

	logic [adg_pkg::OP_W-1:0]   op_q;
	logic [adg_pkg::NODE_W-1:0] a_q, b_q;
	logic [IW-1:0] a_idx, b_idx;
	logic          a_range, b_range;

	logic [NODES-1:0] present_q, rowvld_q;
	logic [NODES-1:0] mat_mem [NODES];
	logic [NODES-1:0] rd_data_q;
	logic             rd_vld_q;
	logic [IW-1:0]    rd_addr, rd_addr_q;
	logic [NODES-1:0] row, b_bit;

	logic [NODES-1:0] seen_q, done_q, frontier, ready_q, visited_q, set_q, set_masked;
	logic [IW-1:0]    pick_f, pick_r, cnt_q, hold_q, stk_rd_q;
	logic [SW-1:0]    deg_q [NODES];
	logic [IW-1:0]    stk_mem [NODES];
	logic [SW-1:0]    sp_q;
	logic             hold_vld_q;
	logic [3:0]       kc_q;
	logic             out_free;
	logic [adg_pkg::SET_W-1:0] set16;

	assign a_range = int'(a_q) < NODES;
	assign b_range = int'(b_q) < NODES;
	assign a_idx   = IW'(a_q);
	assign b_idx   = IW'(b_q);
	assign b_bit   = {{(NODES-1){1'b0}}, 1'b1} << b_idx;
	assign row     = rd_vld_q ? rd_data_q : '0;

	assign frontier = seen_q & ~done_q;
	assign pick_f   = IW'(adg_pkg::lowest_bit(adg_pkg::MAX_NODES'(frontier)));
	assign pick_r   = IW'(adg_pkg::lowest_bit(adg_pkg::MAX_NODES'(ready_q)));

	always_comb begin
		case (cmd.rd_sel)
			adg_pkg::RD_CNT:  rd_addr = cnt_q;
			adg_pkg::RD_A:    rd_addr = a_idx;
			adg_pkg::RD_PICK: rd_addr = pick_f;
			adg_pkg::RD_CUR:  rd_addr = stk_rd_q;
			default:          rd_addr = cnt_q;
		endcase
	end

	// Item fields.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= operation;
			a_q  <= node_a;
			b_q  <= node_b;
		end
	end

	// Matrix memory, one read and one write port.
	always_ff @(posedge clk) begin
		rd_data_q <= mat_mem[rd_addr];
		rd_addr_q <= rd_addr;
		if (cmd.edge_write) begin
			mat_mem[a_idx] <= row | b_bit;
		end
	end

	// Stack memory.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_mem[sp_q[IW-1:0]] <= pick_r;
		end
		if (cmd.pop) begin
			stk_rd_q <= stk_mem[IW'(sp_q - SW'(1))];
		end
	end

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			rowvld_q   <= '0;
			rd_vld_q   <= 1'b0;
			visited_q  <= '0;
			sp_q       <= '0;
			hold_vld_q <= 1'b0;
			kc_q       <= '0;
			cnt_q      <= '0;
		end else begin
			rd_vld_q <= rowvld_q[rd_addr];
			if (cmd.set_present) begin
				present_q[a_idx] <= 1'b1;
			end
			if (cmd.edge_write) begin
				rowvld_q[a_idx] <= 1'b1;
			end
			if (cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (cmd.sort_init) begin
				visited_q  <= '0;
				sp_q       <= '0;
				hold_vld_q <= 1'b0;
				kc_q       <= '0;
			end else begin
				if (cmd.push) begin
					sp_q <= sp_q + SW'(1);
				end else if (cmd.pop) begin
					sp_q <= sp_q - SW'(1);
				end
				if (cmd.visit) begin
					visited_q[stk_rd_q] <= 1'b1;
					if (!hold_vld_q || kc_q != adg_pkg::KC_LAST) begin
						hold_q     <= stk_rd_q;
						hold_vld_q <= 1'b1;
					end
				end
				if (cmd.emit && cmd.emit_node) begin
					kc_q <= kc_q + 4'd1;
				end
			end
		end
	end

	// Search masks, query set, degree lanes and ready mask.
	always_ff @(posedge clk) begin
		if (cmd.reach_init) begin
			seen_q <= b_bit;
			done_q <= '0;
		end
		if (cmd.reach_pick) begin
			done_q[pick_f] <= 1'b1;
		end
		if (cmd.reach_or) begin
			seen_q <= seen_q | row;
		end
		if (cmd.set_clear) begin
			set_q <= '0;
		end
		if (cmd.set_col) begin
			set_q[rd_addr_q] <= row[a_idx];
		end
		if (cmd.set_row) begin
			set_q <= row;
		end
		if (cmd.push) begin
			ready_q[pick_r] <= 1'b0;
		end
		for (int j = 0; j < NODES; j++) begin
			if (cmd.sort_init) begin
				deg_q[j] <= '0;
			end
			if (cmd.deg_acc) begin
				deg_q[j] <= deg_q[j] + SW'(row[j] & present_q[j]);
			end
			if (cmd.ready_init) begin
				ready_q[j] <= present_q[j] && deg_q[j] == '0;
			end
			if (cmd.relax && row[j] && present_q[j] && deg_q[j] != '0) begin
				deg_q[j] <= deg_q[j] - SW'(1);
				if (deg_q[j] == SW'(1)) begin
					ready_q[j] <= 1'b1;
				end
			end
		end
	end

	assign set_masked = set_q & present_q;
	for (genvar k = 0; k < adg_pkg::SET_W; k++) begin : g_set
		if (k < NODES) begin : g_in
			assign set16[k] = set_masked[k];
		end else begin : g_out
			assign set16[k] = 1'b0;
		end
	end

	// Output register: a finished result waits here for the sink.
	assign out_free = !out_valid || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status      <= cmd.emit_status;
			out_node_set    <= cmd.emit_set ? set16 : '0;
			out_order_node  <= cmd.emit_node ? adg_pkg::NODE_W'(hold_q) : '0;
			out_order_valid <= cmd.emit_node;
			out_last        <= cmd.emit_last;
		end
	end

	always_comb begin
		stat.op           = op_q;
		stat.a_range      = a_range;
		stat.a_ok         = a_range && present_q[a_idx];
		stat.b_ok         = b_range && present_q[b_idx];
		stat.cnt_last     = cnt_q == IW'(NODES - 1);
		stat.frontier_any = |frontier;
		stat.reach_hit    = seen_q[a_idx];
		stat.ready_any    = |ready_q;
		stat.stack_empty  = sp_q == '0;
		stat.hold_vld     = hold_vld_q;
		stat.kc_room      = kc_q != adg_pkg::KC_LAST;
		stat.sort_cycle   = visited_q != present_q;
		stat.out_free     = out_free;
	end

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sp_q) <= NODES)
		else $error("stack pointer beyond node count");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result emitted over a waiting result");
	a_visit_present: assert property (@(posedge clk) disable iff (!arst_n)
		(visited_q & ~present_q) == '0)
		else $error("visited node not present");

endmodule
`default_nettype wire

// ----- src/adg_ctrl.sv -----
// Controller state machine sequencing every operation over the datapath.
// Depends on adg_pkg for the command and status structs and codes.
`default_nettype none
module adg_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire adg_pkg::adg_stat_t stat,
	output adg_pkg::adg_cmd_t       cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DEC    = 5'd1;
	localparam logic [4:0] S_EMIT   = 5'd2;
	localparam logic [4:0] S_R_PICK = 5'd3;
	localparam logic [4:0] S_R_OR   = 5'd4;
	localparam logic [4:0] S_E_RD   = 5'd5;
	localparam logic [4:0] S_E_WR   = 5'd6;
	localparam logic [4:0] S_Q_RD   = 5'd7;
	localparam logic [4:0] S_Q_ACC  = 5'd8;
	localparam logic [4:0] S_D_RD   = 5'd9;
	localparam logic [4:0] S_D_ACC  = 5'd10;
	localparam logic [4:0] S_G_RD   = 5'd11;
	localparam logic [4:0] S_G_ACC  = 5'd12;
	localparam logic [4:0] S_RDY    = 5'd13;
	localparam logic [4:0] S_PUSH   = 5'd14;
	localparam logic [4:0] S_POP    = 5'd15;
	localparam logic [4:0] S_VISIT  = 5'd16;
	localparam logic [4:0] S_RELAX  = 5'd17;
	localparam logic [4:0] S_FIN    = 5'd18;
	localparam logic [4:0] S_FIN2   = 5'd19;

	logic [4:0]                   state_q, state_d;
	logic [adg_pkg::STATUS_W-1:0] st_q, st_d;
	logic                         setsel_q, setsel_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = adg_pkg::RD_CNT;
		state_d  = state_q;
		st_d     = st_q;
		setsel_d = setsel_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				st_d     = adg_pkg::ST_OK;
				setsel_d = 1'b0;
				state_d  = S_EMIT;
				case (stat.op)
					adg_pkg::OP_ADD_NODE: begin
						if (stat.a_range) begin
							cmd.set_present = 1'b1;
						end else begin
							st_d = adg_pkg::ST_MISSING;
						end
					end
					adg_pkg::OP_ADD_EDGE: begin
						if (!stat.a_ok || !stat.b_ok) begin
							st_d = adg_pkg::ST_MISSING;
						end else begin
							cmd.reach_init = 1'b1;
							state_d = S_R_PICK;
						end
					end
					adg_pkg::OP_GET_DEPS: begin
						if (!stat.a_ok) begin
							st_d = adg_pkg::ST_MISSING;
						end else begin
							cmd.cnt_clear = 1'b1;
							cmd.set_clear = 1'b1;
							state_d = S_Q_RD;
						end
					end
					adg_pkg::OP_GET_DEPTS: begin
						if (!stat.a_ok) begin
							st_d = adg_pkg::ST_MISSING;
						end else begin
							state_d = S_D_RD;
						end
					end
					adg_pkg::OP_SORT: begin
						cmd.sort_init = 1'b1;
						cmd.cnt_clear = 1'b1;
						state_d = S_G_RD;
					end
					default: begin
						st_d = adg_pkg::ST_OK;
					end
				endcase
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = st_q;
					cmd.emit_set    = setsel_q;
					cmd.emit_last   = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_R_PICK: begin
				if (stat.frontier_any) begin
					cmd.rd_sel     = adg_pkg::RD_PICK;
					cmd.reach_pick = 1'b1;
					state_d = S_R_OR;
				end else if (stat.reach_hit) begin
					st_d    = adg_pkg::ST_EDGE_CYCLE;
					state_d = S_EMIT;
				end else begin
					state_d = S_E_RD;
				end
			end
			S_R_OR: begin
				cmd.reach_or = 1'b1;
				state_d = S_R_PICK;
			end
			S_E_RD: begin
				cmd.rd_sel = adg_pkg::RD_A;
				state_d = S_E_WR;
			end
			S_E_WR: begin
				cmd.edge_write = 1'b1;
				state_d = S_EMIT;
			end
			S_Q_RD: begin
				state_d = S_Q_ACC;
			end
			S_Q_ACC: begin
				cmd.set_col = 1'b1;
				if (stat.cnt_last) begin
					setsel_d = 1'b1;
					state_d  = S_EMIT;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d = S_Q_RD;
				end
			end
			S_D_RD: begin
				cmd.rd_sel = adg_pkg::RD_A;
				state_d = S_D_ACC;
			end
			S_D_ACC: begin
				cmd.set_row = 1'b1;
				setsel_d = 1'b1;
				state_d  = S_EMIT;
			end
			S_G_RD: begin
				state_d = S_G_ACC;
			end
			S_G_ACC: begin
				cmd.deg_acc = 1'b1;
				if (stat.cnt_last) begin
					state_d = S_RDY;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d = S_G_RD;
				end
			end
			S_RDY: begin
				cmd.ready_init = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (stat.ready_any) begin
					cmd.push = 1'b1;
				end else begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (stat.stack_empty) begin
					state_d = S_FIN;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_VISIT;
				end
			end
			S_VISIT: begin
				cmd.rd_sel = adg_pkg::RD_CUR;
				if (stat.hold_vld && stat.kc_room) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_node = 1'b1;
						cmd.visit     = 1'b1;
						state_d = S_RELAX;
					end
				end else begin
					cmd.visit = 1'b1;
					state_d = S_RELAX;
				end
			end
			S_RELAX: begin
				cmd.relax = 1'b1;
				state_d = S_PUSH;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.sort_cycle) begin
						if (stat.hold_vld && stat.kc_room) begin
							cmd.emit_node = 1'b1;
							state_d = S_FIN2;
						end else begin
							cmd.emit_status = adg_pkg::ST_SORT_CYCLE;
							cmd.emit_last   = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						cmd.emit_node = stat.hold_vld;
						cmd.emit_last = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_FIN2: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = adg_pkg::ST_SORT_CYCLE;
					cmd.emit_last   = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			st_q     <= adg_pkg::ST_OK;
			setsel_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			st_q     <= st_d;
			setsel_q <= setsel_d;
		end
	end

endmodule
`default_nettype wire
